// File: hw/rtl/suid_pkg.sv
// ----------------------------------------------------------------------------
// Set union/intersection/difference package
// Shared types, codes and command/status structures for the set engine.
// ----------------------------------------------------------------------------
`default_nettype none

package suid_pkg;

    // Default capacity of each set.
    localparam int MAX_ELEMENTS_DEF = 512;

    // Width of a set element.
    localparam int WORD_W = 32;

    typedef logic signed [WORD_W-1:0] t_word;

    // Input command codes.
    typedef enum logic [1:0] {
        CMD_LOAD_A = 2'd0,
        CMD_LOAD_B = 2'd1,
        CMD_FETCH  = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    // Result status codes.
    typedef enum logic [2:0] {
        STAT_ACCEPT = 3'd0,
        STAT_DUP    = 3'd1,
        STAT_FULL   = 3'd2,
        STAT_ELEM   = 3'd3,
        STAT_END    = 3'd4,
        STAT_DONE   = 3'd5
    } t_status;

    // Result set kinds.
    typedef enum logic [1:0] {
        KIND_UNION = 2'd0,
        KIND_INTER = 2'd1,
        KIND_DIFF  = 2'd2
    } t_kind;

    // Drain phases.
    typedef enum logic [2:0] {
        PH_UNION_A = 3'd0,
        PH_UNION_B = 3'd1,
        PH_INTER   = 3'd2,
        PH_DIFF    = 3'd3,
        PH_DONE    = 3'd4
    } t_phase;

    // Source of the element field of a result.
    typedef enum logic [1:0] {
        ESRC_ZERO = 2'd0,
        ESRC_KEY  = 2'd1,
        ESRC_RD   = 2'd2
    } t_esrc;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE       = 3'd0,
        S_LOAD_SCAN  = 3'd1,
        S_FETCH      = 3'd2,
        S_KEY        = 3'd3,
        S_FETCH_SCAN = 3'd4,
        S_RESP       = 3'd5
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    key_ld_in;   // capture the input value as search key
        logic    scan_start;  // restart the membership scan
        logic    scan_sel;    // set to scan: 0 A, 1 B (taken at scan_start)
        logic    scan_run;    // advance the membership scan
        logic    drain_rd;    // read the drain entry and step the drain index
        logic    rd_sel;      // set read by the drain: 0 A, 1 B
        logic    key_ld_rd;   // capture the drain read data as search key
        logic    phase_set;   // load a new drain phase and zero the index
        t_phase  phase_val;
        logic    wr_a;        // append the key to set A
        logic    wr_b;        // append the key to set B
        logic    clear;       // empty both sets
        logic    res_ld;      // capture a finished result
        t_status res_status;
        t_kind   res_kind;
        t_esrc   res_esrc;
        logic    out_ld;      // move the finished result to the output stage
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic   hit;       // scan found the key
        logic   miss;      // scan finished without finding the key
        logic   idx_lt;    // drain index is below the count of its set
        logic   full_a;
        logic   full_b;
        logic   out_free;  // output stage can take a result this cycle
        t_phase phase;
    } t_dp_sts;

endpackage

`default_nettype wire

// File: hw/rtl/suid_ctrl.sv
// ----------------------------------------------------------------------------
// Set engine controller
// State machine that sequences loads, scans and the result drain.
// ----------------------------------------------------------------------------
`default_nettype none

module suid_ctrl
    import suid_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_cmd    i_in_command,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state, n_state;
    logic   r_load_b, n_load_b;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_load_b <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_load_b <= n_load_b;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        n_load_b   = r_load_b;
        o_cmd      = '0;
        o_in_ready = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (i_in_command)
                        CMD_LOAD_A, CMD_LOAD_B: begin
                            o_cmd.key_ld_in  = 1'b1;
                            o_cmd.scan_start = 1'b1;
                            o_cmd.scan_sel   = (i_in_command == CMD_LOAD_B);
                            o_cmd.phase_set  = 1'b1;
                            o_cmd.phase_val  = PH_UNION_A;
                            n_load_b         = (i_in_command == CMD_LOAD_B);
                            n_state          = S_LOAD_SCAN;
                        end
                        CMD_FETCH: begin
                            n_state = S_FETCH;
                        end
                        default: begin
                            o_cmd.clear      = 1'b1;
                            o_cmd.phase_set  = 1'b1;
                            o_cmd.phase_val  = PH_UNION_A;
                            o_cmd.res_ld     = 1'b1;
                            o_cmd.res_status = STAT_ACCEPT;
                            o_cmd.res_kind   = KIND_UNION;
                            o_cmd.res_esrc   = ESRC_ZERO;
                            n_state          = S_RESP;
                        end
                    endcase
                end
            end

            // Duplicate check, then capacity check, then append.
            S_LOAD_SCAN: begin
                o_cmd.scan_run = 1'b1;
                o_cmd.res_kind = KIND_UNION;
                o_cmd.res_esrc = ESRC_ZERO;
                if (i_sts.hit) begin
                    o_cmd.res_ld     = 1'b1;
                    o_cmd.res_status = STAT_DUP;
                    n_state          = S_RESP;
                end else if (i_sts.miss) begin
                    o_cmd.res_ld = 1'b1;
                    if (r_load_b ? i_sts.full_b : i_sts.full_a) begin
                        o_cmd.res_status = STAT_FULL;
                    end else begin
                        o_cmd.res_status = STAT_ACCEPT;
                        o_cmd.wr_a       = !r_load_b;
                        o_cmd.wr_b       = r_load_b;
                    end
                    n_state = S_RESP;
                end
            end

            // Pick the next drain candidate or close the current phase.
            S_FETCH: begin
                o_cmd.res_esrc = ESRC_ZERO;
                case (i_sts.phase)
                    PH_UNION_A: begin
                        if (i_sts.idx_lt) begin
                            o_cmd.drain_rd = 1'b1;
                            o_cmd.rd_sel   = 1'b0;
                            n_state        = S_KEY;
                        end else begin
                            o_cmd.phase_set = 1'b1;
                            o_cmd.phase_val = PH_UNION_B;
                        end
                    end
                    PH_UNION_B: begin
                        if (i_sts.idx_lt) begin
                            o_cmd.drain_rd = 1'b1;
                            o_cmd.rd_sel   = 1'b1;
                            n_state        = S_KEY;
                        end else begin
                            o_cmd.phase_set  = 1'b1;
                            o_cmd.phase_val  = PH_INTER;
                            o_cmd.res_ld     = 1'b1;
                            o_cmd.res_status = STAT_END;
                            o_cmd.res_kind   = KIND_UNION;
                            n_state          = S_RESP;
                        end
                    end
                    PH_INTER: begin
                        if (i_sts.idx_lt) begin
                            o_cmd.drain_rd = 1'b1;
                            o_cmd.rd_sel   = 1'b0;
                            n_state        = S_KEY;
                        end else begin
                            o_cmd.phase_set  = 1'b1;
                            o_cmd.phase_val  = PH_DIFF;
                            o_cmd.res_ld     = 1'b1;
                            o_cmd.res_status = STAT_END;
                            o_cmd.res_kind   = KIND_INTER;
                            n_state          = S_RESP;
                        end
                    end
                    PH_DIFF: begin
                        if (i_sts.idx_lt) begin
                            o_cmd.drain_rd = 1'b1;
                            o_cmd.rd_sel   = 1'b0;
                            n_state        = S_KEY;
                        end else begin
                            o_cmd.phase_set  = 1'b1;
                            o_cmd.phase_val  = PH_DONE;
                            o_cmd.res_ld     = 1'b1;
                            o_cmd.res_status = STAT_END;
                            o_cmd.res_kind   = KIND_DIFF;
                            n_state          = S_RESP;
                        end
                    end
                    default: begin
                        o_cmd.res_ld     = 1'b1;
                        o_cmd.res_status = STAT_DONE;
                        o_cmd.res_kind   = KIND_UNION;
                        n_state          = S_RESP;
                    end
                endcase
            end

            // Read data is ready: emit it directly or start a membership scan.
            S_KEY: begin
                o_cmd.rd_sel = (i_sts.phase == PH_UNION_B);
                if (i_sts.phase == PH_UNION_A) begin
                    o_cmd.res_ld     = 1'b1;
                    o_cmd.res_status = STAT_ELEM;
                    o_cmd.res_kind   = KIND_UNION;
                    o_cmd.res_esrc   = ESRC_RD;
                    n_state          = S_RESP;
                end else begin
                    o_cmd.key_ld_rd  = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    o_cmd.scan_sel   = (i_sts.phase != PH_UNION_B);
                    n_state          = S_FETCH_SCAN;
                end
            end

            // Membership outcome decides between emitting and skipping.
            S_FETCH_SCAN: begin
                o_cmd.scan_run   = 1'b1;
                o_cmd.res_status = STAT_ELEM;
                o_cmd.res_esrc   = ESRC_KEY;
                case (i_sts.phase)
                    PH_UNION_B: begin
                        o_cmd.res_kind = KIND_UNION;
                        if (i_sts.hit) begin
                            n_state = S_FETCH;
                        end else if (i_sts.miss) begin
                            o_cmd.res_ld = 1'b1;
                            n_state      = S_RESP;
                        end
                    end
                    PH_INTER: begin
                        o_cmd.res_kind = KIND_INTER;
                        if (i_sts.hit) begin
                            o_cmd.res_ld = 1'b1;
                            n_state      = S_RESP;
                        end else if (i_sts.miss) begin
                            n_state = S_FETCH;
                        end
                    end
                    PH_DIFF: begin
                        o_cmd.res_kind = KIND_DIFF;
                        if (i_sts.hit) begin
                            n_state = S_FETCH;
                        end else if (i_sts.miss) begin
                            o_cmd.res_ld = 1'b1;
                            n_state      = S_RESP;
                        end
                    end
                    default: begin
                        n_state = S_FETCH;
                    end
                endcase
            end

            // Hand the result to the output stage once it has room.
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/suid_dp.sv
// ----------------------------------------------------------------------------
// Set engine datapath
// Set memories, counts, drain position, membership scanner and result stages.
// ----------------------------------------------------------------------------
`default_nettype none

module suid_dp
    import suid_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_dp_cmd i_cmd,
    output t_dp_sts      o_sts,
    input  wire t_word   i_value,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    output t_status      o_out_status,
    output t_kind        o_out_kind,
    output t_word        o_out_elem
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ELEMENTS);

    // Set storage.
    t_word mem_a [MAX_ELEMENTS];
    t_word mem_b [MAX_ELEMENTS];

    t_word          r_rd_a, r_rd_b;
    t_word          r_key;
    logic [CW-1:0]  r_cnt_a, r_cnt_b;
    t_phase         r_phase;
    logic [CW-1:0]  r_idx;
    logic [CW-1:0]  r_scan_idx;
    logic           r_scan_sel;
    logic           r_cmp_vld;
    t_status        r_res_status;
    t_kind          r_res_kind;
    t_word          r_res_elem;
    logic           r_out_valid;
    t_status        r_out_status;
    t_kind          r_out_kind;
    t_word          r_out_elem;

    logic           scan_more;
    logic           rd_en_a, rd_en_b;
    logic [AW-1:0]  addr_a, addr_b;
    logic           hit;
    t_word          rd_mux;
    t_word          res_elem;
    logic           out_free;

    // Scan and drain read port selection.
    always_comb begin
        scan_more = r_scan_idx < (r_scan_sel ? r_cnt_b : r_cnt_a);
        rd_en_a   = (i_cmd.drain_rd && !i_cmd.rd_sel)
                    || (i_cmd.scan_run && !r_scan_sel && scan_more);
        rd_en_b   = (i_cmd.drain_rd && i_cmd.rd_sel)
                    || (i_cmd.scan_run && r_scan_sel && scan_more);
        addr_a    = i_cmd.drain_rd ? r_idx[AW-1:0] : r_scan_idx[AW-1:0];
        addr_b    = i_cmd.drain_rd ? r_idx[AW-1:0] : r_scan_idx[AW-1:0];
        hit       = r_cmp_vld && ((r_scan_sel ? r_rd_b : r_rd_a) == r_key);
        rd_mux    = i_cmd.rd_sel ? r_rd_b : r_rd_a;
        out_free  = !r_out_valid || i_out_ready;
    end

    // Memory A: one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a) begin
            mem_a[r_cnt_a[AW-1:0]] <= r_key;
        end
        if (rd_en_a) begin
            r_rd_a <= mem_a[addr_a];
        end
    end

    // Memory B: one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_b) begin
            mem_b[r_cnt_b[AW-1:0]] <= r_key;
        end
        if (rd_en_b) begin
            r_rd_b <= mem_b[addr_b];
        end
    end

    // Set counts, drain position and scanner control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a    <= '0;
            r_cnt_b    <= '0;
            r_phase    <= PH_UNION_A;
            r_idx      <= '0;
            r_scan_idx <= '0;
            r_scan_sel <= 1'b0;
            r_cmp_vld  <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_cnt_a <= '0;
                r_cnt_b <= '0;
            end else begin
                if (i_cmd.wr_a) begin
                    r_cnt_a <= r_cnt_a + 1'b1;
                end
                if (i_cmd.wr_b) begin
                    r_cnt_b <= r_cnt_b + 1'b1;
                end
            end

            if (i_cmd.phase_set) begin
                r_phase <= i_cmd.phase_val;
                r_idx   <= '0;
            end else if (i_cmd.drain_rd) begin
                r_idx <= r_idx + 1'b1;
            end

            if (i_cmd.scan_start) begin
                r_scan_idx <= '0;
                r_scan_sel <= i_cmd.scan_sel;
                r_cmp_vld  <= 1'b0;
            end else if (i_cmd.scan_run) begin
                r_cmp_vld <= scan_more;
                if (scan_more) begin
                    r_scan_idx <= r_scan_idx + 1'b1;
                end
            end else begin
                r_cmp_vld <= 1'b0;
            end
        end
    end

    // Search key.
    always_ff @(posedge i_clk) begin
        if (i_cmd.key_ld_in) begin
            r_key <= i_value;
        end else if (i_cmd.key_ld_rd) begin
            r_key <= rd_mux;
        end
    end

    // Finished result waiting for the output stage.
    always_comb begin
        case (i_cmd.res_esrc)
            ESRC_KEY: res_elem = r_key;
            ESRC_RD:  res_elem = rd_mux;
            default:  res_elem = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_ld) begin
            r_res_status <= i_cmd.res_status;
            r_res_kind   <= i_cmd.res_kind;
            r_res_elem   <= res_elem;
        end
    end

    // Output stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_out_status <= r_res_status;
            r_out_kind   <= r_res_kind;
            r_out_elem   <= r_res_elem;
        end
    end

    // Status to the controller.
    always_comb begin
        o_sts.hit      = hit;
        o_sts.miss     = !hit && !scan_more;
        o_sts.idx_lt   = r_idx < ((r_phase == PH_UNION_B) ? r_cnt_b : r_cnt_a);
        o_sts.full_a   = (r_cnt_a == CNT_MAX);
        o_sts.full_b   = (r_cnt_b == CNT_MAX);
        o_sts.out_free = out_free;
        o_sts.phase    = r_phase;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_kind   = r_out_kind;
    assign o_out_elem   = r_out_elem;

endmodule

`default_nettype wire

// File: hw/rtl/set_union_intersection_difference_core.sv
// Load: the time from acceptance to result is set by the linear duplicate scan of
// the target set (one entry per cycle through its registered memory port).
// Fetch: steps through each phase's candidates and closes a phase or gives done once none
// are left; past the union from A, each visited candidate is checked by a membership scan.
// One transaction at a time: the next is accepted the cycle after its result is staged.
// Synchronous active-low reset empties both sets and restarts the drain; memories keep data.
// ----------------------------------------------------------------------------
// Set union/intersection/difference core
// Loads two sets of signed words and drains their union, intersection and
// difference, one result transaction per input transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module set_union_intersection_difference_core
    import suid_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] value
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] command
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] element
    output logic [4:0]       m_axis_tuser    // [2:0] status, [4:3] set_kind
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    t_status out_status;
    t_kind   out_kind;
    t_word   out_elem;

    // Sequencer.
    suid_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_in_command (t_cmd'(s_axis_tuser)),
        .i_sts        (dp_sts),
        .o_cmd        (dp_cmd)
    );

    // Storage, scanner and result stages.
    suid_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .i_value      (t_word'(s_axis_tdata)),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_status (out_status),
        .o_out_kind   (out_kind),
        .o_out_elem   (out_elem)
    );

    assign m_axis_tdata = out_elem;
    assign m_axis_tuser = {out_kind, out_status};

endmodule

`default_nettype wire

// File: hw/rtl/suid_chk.sv
// ----------------------------------------------------------------------------
// Set engine port checker
// Concurrent assertions on the top-level ports, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module suid_chk
    import suid_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [31:0] i_m_tdata,
    input wire logic [4:0]  i_m_tuser
);

    // A result is never presented in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result valid after reset");

    // A stalled result stays presented.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tuser)
                                      && $stable(i_m_tdata))
        else $error("stalled result changed");

    // The element is zero unless the result carries an element.
    a_elem_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && (i_m_tuser[2:0] != STAT_ELEM) |-> i_m_tdata == '0)
        else $error("element set on a non-element result");

    // Set kind is only given with an element or an end marker.
    a_kind_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && (i_m_tuser[2:0] != STAT_ELEM) && (i_m_tuser[2:0] != STAT_END)
        |-> i_m_tuser[4:3] == KIND_UNION)
        else $error("set kind set on a load or done result");

    // Status codes and set kinds stay within their defined ranges.
    a_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (i_m_tuser[2:0] <= STAT_DONE) && (i_m_tuser[4:3] <= KIND_DIFF))
        else $error("undefined status or set kind");

endmodule

bind set_union_intersection_difference_core suid_chk u_suid_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser)
);

`default_nettype wire
